// ===== design/ole_pkg.sv =====
// Shared types and codes for the ordered list engine.
// Item structs, command and status codes, and the neighbor link that
// runs through the cell row. No dependencies.
`default_nettype none

package ole_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_ORDERED    = 3'd2,
		CMD_REMOVE     = 3'd3,
		CMD_POP_FRONT  = 3'd4,
		CMD_POP_BACK   = 3'd5,
		CMD_QUERY      = 3'd6
	} cmd_e;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_e;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] value;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic [4:0]         entry_total;
	} rsp_item_t;

	// Passed from each cell to the next one toward the tail.
	typedef struct packed {
		logic        after;   // target position is at or before this cell
		logic        hit;     // target cell held the value (remove)
		logic [31:0] data;    // entry of the target cell, zero elsewhere
	} link_t;

endpackage

`default_nettype wire

// ===== design/ole_cell.sv =====
// One list position of the ordered list engine.
// Holds one entry, compares it against the command value and shifts
// toward or away from the head. Uses ole_pkg.
`default_nettype none

module ole_cell
	import ole_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  wire logic              clk,
	input  wire cmd_item_t         item,
	input  wire logic [CW-1:0]     count,
	input  wire logic [CW-1:0]     last,
	input  wire logic              ins_en,
	input  wire logic              del_en,
	input  wire logic signed [31:0] left_entry,
	input  wire logic signed [31:0] right_entry,
	input  wire link_t             link_in,
	output link_t                  link_out,
	output logic signed [31:0]     entry
);

	localparam logic [CW-1:0] IDX_C = IDX[CW-1:0];

	logic signed [31:0] entry_q;
	logic in_use;
	logic self_hit;
	logic at_or_after;
	logic sel;

	assign in_use = IDX_C < count;

	// Does the target position land on this cell, given the command
	always_comb begin
		case (cmd_e'(item.command))
			CMD_PUSH_FRONT, CMD_POP_FRONT: self_hit = (IDX == 0);
			CMD_PUSH_BACK:  self_hit = (IDX_C == count);
			CMD_ORDERED:    self_hit = (in_use && (entry_q > item.value)) || (IDX_C == count);
			CMD_REMOVE:     self_hit = in_use && !(entry_q < item.value);
			CMD_POP_BACK:   self_hit = (IDX_C == last);
			default:        self_hit = 1'b0;
		endcase
	end

	assign at_or_after = link_in.after | self_hit;
	assign sel         = at_or_after && !link_in.after && in_use;

	always_comb begin
		link_out.after = at_or_after;
		link_out.hit   = link_in.hit | (sel && (entry_q == item.value));
		link_out.data  = link_in.data | (sel ? entry_q : 32'd0);
	end

	always_ff @(posedge clk) begin
		if (ins_en && at_or_after) begin
			entry_q <= link_in.after ? left_entry : item.value;
		end else if (del_en && at_or_after) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

// ===== design/ordered_list_engine_top.sv =====
// Ordered list engine: a bounded list of signed 32-bit entries held in a
// row of cells. Uses ole_pkg and ole_cell.
//
// Usage:
//  - Command channel (cmd_valid / cmd_stall / cmd_item): one item carries a
//    command code and a value. An item is taken at a rising edge with
//    cmd_valid high and cmd_stall low.
//  - Response channel (rsp_valid / rsp_stall / rsp_item): exactly one item
//    per command, with status, removed value and the count after the command.
//  - A taken command is held in item_s1; its response is written to the
//    output register when the cell row commits, visible on rsp_valid after.
//  - A new command is not taken until the previous one commits. The whole
//    cell row is updated together for every command: all cells compare at
//    once and a position chain picks the target cell; cmd_stall is high
//    from each accept until that update commits.
//  - A finished response may wait in the output register while the next
//    command is taken; that command only completes once the register frees.
//  - If the receiver holds rsp_stall, the response holds and the engine
//    stops after taking at most one more command.
//  - Reset (arst_n low) empties the list and drops any pending response.
//    Entry storage is not cleared; the count alone marks what is held.
//  - Full inserts, removes/pops on an empty list and remove misses report
//    their status and leave the list unchanged.
`default_nettype none

module ordered_list_engine_top
	import ole_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire cmd_item_t cmd_item,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_item_t      rsp_item
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CAPACITY[CW-1:0];

	// Command held for the cell update
	cmd_item_t item_s1;
	logic      busy_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] last;
	logic          full;
	logic          empty;
	logic          commit;
	logic          ins_en;
	logic          del_en;

	logic      rsp_valid_q;
	rsp_item_t rsp_q;

	link_t              link   [0:CAPACITY];
	logic signed [31:0] entries[0:CAPACITY-1];

	logic [1:0]      status;
	logic [CW-1:0]   count_nxt;
	logic [CW+4:0]   total_wide;

	assign cmd_stall = busy_q;
	assign full      = count_q >= CAP_C;
	assign empty     = count_q == '0;
	assign last      = count_q - CW'(1);

	// Update the cells only when the output register can take the response
	assign commit = busy_q && (!rsp_valid_q || !rsp_stall);

	assign link[0] = '{after: 1'b0, hit: 1'b0, data: 32'd0};

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic signed [31:0] left_e;
			logic signed [31:0] right_e;
			if (i == 0) begin : g_head
				assign left_e = item_s1.value;
			end else begin : g_mid
				assign left_e = entries[i-1];
			end
			if (i == CAPACITY - 1) begin : g_tail
				assign right_e = entries[i];
			end else begin : g_body
				assign right_e = entries[i+1];
			end
			ole_cell #(.IDX(i), .CW(CW)) u_cell (
				.clk         (clk),
				.item        (item_s1),
				.count       (count_q),
				.last        (last),
				.ins_en      (ins_en),
				.del_en      (del_en),
				.left_entry  (left_e),
				.right_entry (right_e),
				.link_in     (link[i]),
				.link_out    (link[i+1]),
				.entry       (entries[i])
			);
		end
	endgenerate

	// Decide the action and status from the chain tail
	always_comb begin
		ins_en = 1'b0;
		del_en = 1'b0;
		status = ST_OK;
		case (cmd_e'(item_s1.command))
			CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_ORDERED: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					ins_en = commit;
				end
			end
			CMD_REMOVE: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (!link[CAPACITY].hit) begin
					status = ST_NOT_FOUND;
				end else begin
					del_en = commit;
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					del_en = commit;
				end
			end
			default: status = ST_OK;
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (ins_en) begin
			count_nxt = count_q + CW'(1);
		end else if (del_en) begin
			count_nxt = count_q - CW'(1);
		end
	end

	assign total_wide = {5'd0, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			count_q <= count_nxt;
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1 <= cmd_item;
		end
		if (commit) begin
			rsp_q.status        <= status;
			rsp_q.removed_value <= (ins_en || del_en) && !ins_en ? link[CAPACITY].data : 32'd0;
			rsp_q.entry_total   <= total_wide[4:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_busy_clears: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !rsp_valid_q |=> !busy_q)
		else $error("command not completed with output register free");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		commit && status == ST_FULL |-> count_q == CAP_C)
		else $error("full status with room left");

	a_pending_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_stall |=> rsp_valid_q)
		else $error("stalled response dropped");

endmodule

`default_nettype wire

// ===== test/ole_list_checker.sv =====
`timescale 1ns / 100ps
// Checker for the ordered list engine: watches both channels, keeps its own
// copy of the list and compares every response. Depends on ole_pkg.

module ole_list_checker
	import ole_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic      cmd_stall,
	input  cmd_item_t cmd_item,
	input  logic      rsp_valid,
	input  logic      rsp_stall,
	input  rsp_item_t rsp_item,
	output int        pending,
	output int        fail_count
);

	logic signed [31:0] list_copy [CAPACITY];
	int                 held;
	rsp_item_t          awaited_rsps [$];
	int                 fails;

	function automatic logic signed [31:0] take_entry(int pos);
		logic signed [31:0] v;
		v = list_copy[pos];
		for (int i = pos; i + 1 < held; i++)
			list_copy[i] = list_copy[i + 1];
		held--;
		return v;
	endfunction

	// Apply one command to the copy and return the response it must produce.
	function automatic rsp_item_t list_response(cmd_item_t it);
		rsp_item_t          r;
		int                 pos;
		logic signed [31:0] v;
		v = it.value;
		r.status = ST_OK;
		r.removed_value = '0;
		case (it.command)
			CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_ORDERED: begin
				if (held >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					if (it.command == CMD_PUSH_FRONT)
						pos = 0;
					else if (it.command == CMD_PUSH_BACK || held == 0)
						pos = held;
					else if (v < list_copy[0])
						pos = 0;
					else begin
						pos = 1;
						while (pos < held && v >= list_copy[pos])
							pos++;
					end
					for (int i = held; i > pos; i--)
						list_copy[i] = list_copy[i - 1];
					list_copy[pos] = v;
					held++;
				end
			end
			CMD_REMOVE: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					pos = 0;
					while (pos < held && list_copy[pos] < v)
						pos++;
					if (pos < held && list_copy[pos] == v)
						r.removed_value = take_entry(pos);
					else
						r.status = ST_NOT_FOUND;
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (held == 0)
					r.status = ST_EMPTY;
				else
					r.removed_value = take_entry(it.command == CMD_POP_FRONT ? 0 : held - 1);
			end
			default: ;
		endcase
		r.entry_total = held[4:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			held = 0;
			awaited_rsps.delete();
			fails = 0;
		end else begin
			// responses first: one accepted at this edge never belongs to
			// a command taken at the same edge
			if (rsp_valid && !rsp_stall) begin
				if (awaited_rsps.size() == 0) begin
					$error("response with no command waiting: status %0d", rsp_item.status);
					fails++;
				end else begin
					want = awaited_rsps.pop_front();
					if (rsp_item.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp_item.status);
						fails++;
					end
					if (rsp_item.removed_value !== want.removed_value) begin
						$error("removed_value: expected %0d, actual %0d",
							want.removed_value, rsp_item.removed_value);
						fails++;
					end
					if (rsp_item.entry_total !== want.entry_total) begin
						$error("entry_total: expected %0d, actual %0d",
							want.entry_total, rsp_item.entry_total);
						fails++;
					end
				end
			end
			if (cmd_valid && !cmd_stall)
				awaited_rsps.push_back(list_response(cmd_item));
		end
		pending <= awaited_rsps.size();
		fail_count <= fails;
	end

endmodule

// ===== test/tb_ordered_list_engine_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the ordered list engine: clock, reset, command stimulus
// and response back-pressure. Depends on ole_pkg, ole_list_checker and the
// engine RTL.

module tb_ordered_list_engine_top;
	import ole_pkg::*;

	localparam int          CAPACITY    = 16;
	localparam int          RANDOM_CMDS = 1530;
	localparam int          CYCLE_LIMIT = 400000;
	localparam logic [2:0]  CMD_UNUSED  = 3'd7;   // spare code, behaves as a query
	localparam logic [31:0] VAL_MAX     = 32'h7fff_ffff;
	localparam logic [31:0] VAL_MIN     = 32'h8000_0000;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_item_t cmd_item;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_item_t rsp_item;
	int        pending;
	int        fail_count;
	bit        cmd_no_idle;   // sender runs back to back while set
	int        rsp_edges;

	ordered_list_engine_top #(.CAPACITY(CAPACITY)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_item  (cmd_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	ole_list_checker #(.CAPACITY(CAPACITY)) list_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd_item   (cmd_item),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_item   (rsp_item),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always #10 clk = ~clk;

	// Receiver back-pressure: stall at random about 23 percent of the time, except
	// for a long quiet window where every response is taken at once.
	always @(posedge clk) begin
		rsp_edges <= rsp_edges + 1;
		if (!arst_n || (rsp_edges > 3000 && rsp_edges < 4500))
			rsp_stall <= 1'b0;
		else
			rsp_stall <= ($urandom_range(0, 99) < 23);
	end

	// Hold one command item on the channel until the engine takes it. Idle
	// gaps go in front of it at random so they land on every phase.
	task automatic send_command(logic [2:0] op, logic [31:0] v);
		while (!cmd_no_idle && $urandom_range(0, 99) < 23) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_item.command <= op;
		cmd_item.value <= v;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	// Drop valid and hold off until every response is back.
	task automatic drain_responses();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Mostly small values so removes find their targets and duplicates occur;
	// some extremes; the rest full range so every bit toggles.
	function automatic logic [31:0] pick_value();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return int'($urandom_range(0, 16)) - 8;
		if (pick < 65) begin
			case ($urandom_range(0, 3))
				0: return VAL_MAX;
				1: return VAL_MIN;
				2: return 32'h0;
				default: return 32'hffff_ffff;
			endcase
		end
		return $urandom;
	endfunction

	// Pick a command for the current phase: fill favors inserts so the list
	// reaches full, drain favors removes and pops so it runs empty.
	function automatic logic [2:0] pick_command(int phase);
		int roll;
		roll = $urandom_range(0, 99);
		case (phase)
			0: begin
				if (roll < 75)
					return (roll < 25) ? CMD_PUSH_FRONT : (roll < 45) ? CMD_PUSH_BACK : CMD_ORDERED;
			end
			1: begin
				if (roll < 75)
					return (roll < 35) ? CMD_REMOVE : (roll < 55) ? CMD_POP_FRONT : CMD_POP_BACK;
			end
			default: ;
		endcase
		return 3'($urandom_range(0, 7));
	endfunction

	initial begin
		int phase;
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd_item = '0;
		rsp_stall = 1'b0;
		rsp_edges = 0;
		cmd_no_idle = 1'b0;
		phase = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty-list errors, spare code, single-entry pop back,
		// ordered insert at head, middle, among equals and at the back, removes
		// that hit the head, a duplicate and the tail, and a miss.
		send_command(CMD_QUERY, 32'h0);
		send_command(CMD_POP_FRONT, 32'h0);
		send_command(CMD_POP_BACK, 32'h0);
		send_command(CMD_REMOVE, 32'd5);
		send_command(CMD_UNUSED, 32'h1234_5678);
		send_command(CMD_PUSH_BACK, VAL_MAX);
		send_command(CMD_POP_BACK, 32'h0);
		send_command(CMD_ORDERED, 32'd10);
		send_command(CMD_ORDERED, -32'sd5);
		send_command(CMD_ORDERED, 32'd10);
		send_command(CMD_ORDERED, 32'd3);
		send_command(CMD_ORDERED, VAL_MAX);
		send_command(CMD_PUSH_FRONT, VAL_MIN);
		send_command(CMD_REMOVE, 32'd4);
		send_command(CMD_REMOVE, VAL_MIN);
		send_command(CMD_REMOVE, 32'd10);
		send_command(CMD_REMOVE, VAL_MAX);
		send_command(CMD_REMOVE, VAL_MAX);
		send_command(CMD_PUSH_BACK, 32'hffff_ffff);
		send_command(CMD_QUERY, VAL_MIN);
		send_command(CMD_POP_FRONT, 32'h0);
		send_command(CMD_POP_BACK, 32'h0);
		drain_responses();

		// Random part in phases of 40 commands; one stretch runs with no
		// sender idling, and the sender drains the engine once midway.
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (n % 40 == 0)
				phase = $urandom_range(0, 2);
			cmd_no_idle = (n >= 1000 && n < 1300);
			if (n == 700)
				drain_responses();
			send_command(pick_command(phase), pick_value());
		end
		drain_responses();
		repeat (4) @(posedge clk);

		if (fail_count == 0)
			$display("ordered_list_engine_top: match");
		else
			$display("ordered_list_engine_top: mismatch");
		$finish;
	end

	// Watchdog: end the run if the engine stops making progress.
	initial begin
		int cycles;
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("ordered_list_engine_top: mismatch");
		$finish;
	end

endmodule

// ===== ordered_list_engine_top.f =====
design/ole_pkg.sv
design/ole_cell.sv
design/ordered_list_engine_top.sv
test/ole_list_checker.sv
test/tb_ordered_list_engine_top.sv
